>>> hdl/trc_pkg.sv
// shared types, codes and constants for the two-register cpu core
`timescale 1ns / 1ps
`default_nettype none
package trc_pkg;

	// data memory geometry
	localparam int DATA_WORDS = 65536;
	localparam int DATA_AW    = $clog2(DATA_WORDS);

	// default program store depth
	localparam int PROGRAM_WORDS_DEF = 32768;

	// item kinds
	localparam logic [1:0] K_LOAD    = 2'd0;
	localparam logic [1:0] K_STEP    = 2'd1;
	localparam logic [1:0] K_READ    = 2'd2;
	localparam logic [1:0] K_RESTART = 2'd3;

	// result status codes
	localparam logic [2:0] ST_OK      = 3'd0;
	localparam logic [2:0] ST_HALT    = 3'd1;
	localparam logic [2:0] ST_PASS    = 3'd2;
	localparam logic [2:0] ST_PC      = 3'd3;
	localparam logic [2:0] ST_LIMIT   = 3'd4;
	localparam logic [2:0] ST_ILLEGAL = 3'd5;

	// configuration register indexes
	localparam logic [1:0] REG_PROG_LEN  = 2'd0;
	localparam logic [1:0] REG_STEP_LIM  = 2'd1;
	localparam logic [1:0] REG_HALT_ADDR = 2'd2;
	localparam logic [1:0] REG_PASS_ADDR = 2'd3;

	// configuration reset values
	localparam logic [15:0] PROG_LEN_RST  = 16'd0;
	localparam logic [63:0] STEP_LIM_RST  = 64'hFFFF_FFFF_FFFF_FFFF;
	localparam logic [15:0] HALT_ADDR_RST = 16'd30001;
	localparam logic [15:0] PASS_ADDR_RST = 16'd30000;

	// data memory access request from the core
	typedef struct packed {
		logic [DATA_AW-1:0] raddr0;
		logic [DATA_AW-1:0] raddr1;
		logic               we;
		logic [DATA_AW-1:0] waddr;
		logic [15:0]        wdata;
	} dmem_req_t;

endpackage
`default_nettype wire

>>> hdl/trc_dmem.sv
// data memory with two read ports, one write port and a clearing sweep
`timescale 1ns / 1ps
`default_nettype none
module trc_dmem (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire trc_pkg::dmem_req_t        req,
	input  wire logic                      clr_start,
	output logic [15:0]                    rdata0,
	output logic [15:0]                    rdata1,
	output logic                           clr_busy
);

	logic [15:0] mem [trc_pkg::DATA_WORDS];

	logic [trc_pkg::DATA_AW-1:0] clr_cnt_q;
	logic                        clr_busy_q;

	logic                        wr_en;
	logic [trc_pkg::DATA_AW-1:0] wr_addr;
	logic [15:0]                 wr_data;

	// the sweep owns the write port while it runs
	assign wr_en    = clr_busy_q | req.we;
	assign wr_addr  = clr_busy_q ? clr_cnt_q : req.waddr;
	assign wr_data  = clr_busy_q ? 16'd0 : req.wdata;
	assign clr_busy = clr_busy_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_busy_q <= 1'b1;
			clr_cnt_q  <= '0;
		end else if (clr_start) begin
			clr_busy_q <= 1'b1;
			clr_cnt_q  <= '0;
		end else if (clr_busy_q) begin
			clr_cnt_q <= clr_cnt_q + 1'b1;
			if (clr_cnt_q == trc_pkg::DATA_AW'(trc_pkg::DATA_WORDS - 1)) begin
				clr_busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rdata0 <= mem[req.raddr0];
		rdata1 <= mem[req.raddr1];
	end

endmodule
`default_nettype wire

>>> hdl/two_register_cpu_core.sv
// two-register cpu core: sequencer, registers, program store and alu
// path from accept to result word: load via DONE, read via RD and DONE, A-instruction or
// stop via CHK and DONE, C-instruction via CHK, EXE and DONE; memory reads are registered
// one item at a time: the next word is taken in the cycle after the result is registered
// reset and each restart sweep the data memory to zero, no item is taken meanwhile and a
// restart answers once the sweep is done; configuration is always taken
`timescale 1ns / 1ps
`default_nettype none
module two_register_cpu_core #(
	parameter int PROGRAM_WORDS = trc_pkg::PROGRAM_WORDS_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [1:0]  kind,
	input  wire logic [15:0] address,
	input  wire logic [15:0] word,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [2:0]       status,
	output logic [15:0]      program_counter,
	output logic [15:0]      a_value,
	output logic [15:0]      d_value,
	output logic [15:0]      read_word,
	output logic [63:0]      steps_done,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [63:0] cfg_data
);

	localparam int          PW_AW  = $clog2(PROGRAM_WORDS);
	localparam logic [16:0] PW_LIM = 17'(PROGRAM_WORDS);

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_CHK  = 3'd1;
	localparam logic [2:0] S_EXE  = 3'd2;
	localparam logic [2:0] S_RD   = 3'd3;
	localparam logic [2:0] S_CLR  = 3'd4;
	localparam logic [2:0] S_DONE = 3'd5;

	function automatic logic [15:0] alu(input logic [6:0] code, input logic [15:0] d,
			input logic [15:0] y);
		logic [15:0] r;
		case (code) inside
			7'h2A:        r = 16'h0000;
			7'h3F:        r = 16'h0001;
			7'h3A:        r = 16'hFFFF;
			7'h0C:        r = d;
			7'h30, 7'h70: r = y;
			7'h0D:        r = ~d;
			7'h31, 7'h71: r = ~y;
			7'h0F:        r = 16'h0000 - d;
			7'h33, 7'h73: r = 16'h0000 - y;
			7'h1F:        r = d + 16'h0001;
			7'h37, 7'h77: r = y + 16'h0001;
			7'h0E:        r = d - 16'h0001;
			7'h32, 7'h72: r = y - 16'h0001;
			7'h02, 7'h42: r = d + y;
			7'h13, 7'h53: r = d - y;
			7'h07, 7'h47: r = y - d;
			7'h00, 7'h40: r = d & y;
			7'h15, 7'h55: r = d | y;
			default:      r = 16'h0000;
		endcase
		return r;
	endfunction

	// configuration
	logic [15:0] prog_len_q;
	logic [63:0] step_lim_q;
	logic [15:0] halt_addr_q;
	logic [15:0] pass_addr_q;

	// architectural state
	logic [15:0] a_q;
	logic [15:0] d_q;
	logic [15:0] pc_q;
	logic [63:0] steps_q;

	logic [2:0]  state_q;
	logic [15:0] instr_q;
	logic [2:0]  res_status_q;
	logic [15:0] res_read_q;

	logic        out_valid_q;
	logic [2:0]  out_status_q;
	logic [15:0] out_pc_q;
	logic [15:0] out_a_q;
	logic [15:0] out_d_q;
	logic [15:0] out_read_q;
	logic [63:0] out_steps_q;

	// program store
	logic [15:0] prog_mem [PROGRAM_WORDS];
	logic [15:0] prog_rdata;
	logic        prog_we;

	// data memory
	trc_pkg::dmem_req_t dreq;
	logic               clr_start;
	logic [15:0]        drdata0;
	logic [15:0]        drdata1;
	logic               clr_busy;

	logic        in_acc;
	logic [16:0] len_eff;
	logic        chk_halt;
	logic        chk_pass;
	logic        chk_pc;
	logic        chk_lim;
	logic [15:0] alu_y;
	logic [15:0] alu_r;
	logic [15:0] a_new;
	logic        jmp;
	logic        out_free;

	assign cfg_ready = 1'b1;
	assign in_ready  = (state_q == S_IDLE) && !clr_busy;
	assign in_acc    = in_valid && in_ready;
	assign out_free  = !out_valid_q || out_ready;

	assign len_eff  = ({1'b0, prog_len_q} > PW_LIM) ? PW_LIM : {1'b0, prog_len_q};
	assign chk_halt = (drdata0 != 16'd0);
	assign chk_pass = (drdata1 != 16'd0);
	assign chk_pc   = ({1'b0, pc_q} >= len_eff);
	assign chk_lim  = (steps_q >= step_lim_q);

	// C-instruction: y picks M when the a-bit is set
	assign alu_y = instr_q[12] ? drdata0 : a_q;
	assign alu_r = alu(instr_q[12:6], d_q, alu_y);
	assign a_new = instr_q[5] ? alu_r : a_q;
	assign jmp   = (instr_q[2] && alu_r[15]) || (instr_q[1] && (alu_r == 16'd0)) ||
		(instr_q[0] && !alu_r[15] && (alu_r != 16'd0));

	assign prog_we = in_acc && (kind == trc_pkg::K_LOAD) && ({1'b0, address} < PW_LIM);

	always_ff @(posedge clk) begin
		if (prog_we) begin
			prog_mem[address[PW_AW-1:0]] <= word;
		end
		prog_rdata <= prog_mem[pc_q[PW_AW-1:0]];
	end

	always_comb begin
		dreq.raddr0 = a_q;
		if (state_q == S_IDLE) begin
			dreq.raddr0 = (kind == trc_pkg::K_READ) ? address : halt_addr_q;
		end
		dreq.raddr1 = pass_addr_q;
		dreq.we     = (state_q == S_EXE) && instr_q[3];
		// memory write goes to the old A
		dreq.waddr  = a_q;
		dreq.wdata  = alu_r;
	end

	assign clr_start = in_acc && (kind == trc_pkg::K_RESTART);

	trc_dmem u_dmem (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (dreq),
		.clr_start (clr_start),
		.rdata0    (drdata0),
		.rdata1    (drdata1),
		.clr_busy  (clr_busy)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prog_len_q  <= trc_pkg::PROG_LEN_RST;
			step_lim_q  <= trc_pkg::STEP_LIM_RST;
			halt_addr_q <= trc_pkg::HALT_ADDR_RST;
			pass_addr_q <= trc_pkg::PASS_ADDR_RST;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				trc_pkg::REG_PROG_LEN:  prog_len_q  <= cfg_data[15:0];
				trc_pkg::REG_STEP_LIM:  step_lim_q  <= cfg_data;
				trc_pkg::REG_HALT_ADDR: halt_addr_q <= cfg_data[15:0];
				trc_pkg::REG_PASS_ADDR: pass_addr_q <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			a_q          <= '0;
			d_q          <= '0;
			pc_q         <= '0;
			steps_q      <= '0;
			instr_q      <= '0;
			res_status_q <= trc_pkg::ST_OK;
			res_read_q   <= '0;
			out_valid_q  <= 1'b0;
			out_status_q <= trc_pkg::ST_OK;
			out_pc_q     <= '0;
			out_a_q      <= '0;
			out_d_q      <= '0;
			out_read_q   <= '0;
			out_steps_q  <= '0;
		end else begin
			if ((state_q == S_DONE) && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						res_status_q <= trc_pkg::ST_OK;
						res_read_q   <= 16'd0;
						unique case (kind)
							trc_pkg::K_LOAD: state_q <= S_DONE;
							trc_pkg::K_STEP: state_q <= S_CHK;
							trc_pkg::K_READ: state_q <= S_RD;
							trc_pkg::K_RESTART: begin
								a_q     <= '0;
								d_q     <= '0;
								pc_q    <= '0;
								steps_q <= '0;
								state_q <= S_CLR;
							end
							default: state_q <= S_DONE;
						endcase
					end
				end
				S_CHK: begin
					state_q <= S_DONE;
					if (chk_halt) begin
						res_status_q <= trc_pkg::ST_HALT;
					end else if (chk_pass) begin
						res_status_q <= trc_pkg::ST_PASS;
					end else if (chk_pc) begin
						res_status_q <= trc_pkg::ST_PC;
					end else if (chk_lim) begin
						res_status_q <= trc_pkg::ST_LIMIT;
					end else if (!prog_rdata[15]) begin
						a_q     <= {1'b0, prog_rdata[14:0]};
						pc_q    <= pc_q + 16'd1;
						steps_q <= steps_q + 64'd1;
					end else if (prog_rdata[15:13] == 3'b111) begin
						// M operand read at A is in flight
						instr_q <= prog_rdata;
						state_q <= S_EXE;
					end else begin
						res_status_q <= trc_pkg::ST_ILLEGAL;
					end
				end
				S_EXE: begin
					a_q     <= a_new;
					if (instr_q[4]) begin
						d_q <= alu_r;
					end
					pc_q    <= jmp ? a_new : pc_q + 16'd1;
					steps_q <= steps_q + 64'd1;
					state_q <= S_DONE;
				end
				S_RD: begin
					res_read_q <= drdata0;
					state_q    <= S_DONE;
				end
				S_CLR: begin
					if (!clr_busy) begin
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (out_free) begin
						out_status_q <= res_status_q;
						out_pc_q     <= pc_q;
						out_a_q      <= a_q;
						out_d_q      <= d_q;
						out_read_q   <= res_read_q;
						out_steps_q  <= steps_q;
						state_q      <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign out_valid       = out_valid_q;
	assign status          = out_status_q;
	assign program_counter = out_pc_q;
	assign a_value         = out_a_q;
	assign d_value         = out_d_q;
	assign read_word       = out_read_q;
	assign steps_done      = out_steps_q;

endmodule
`default_nettype wire

>>> hdl/trc_checker.sv
// port-level checks for the two-register cpu core, bound to the top level
`timescale 1ns / 1ps
`default_nettype none
module trc_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        in_valid,
	input wire logic        in_ready,
	input wire logic        out_valid,
	input wire logic        out_ready,
	input wire logic [2:0]  status,
	input wire logic [15:0] read_word,
	input wire logic [63:0] steps_done
);

	// a result word waiting for the sink stays put
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(status) && $stable(read_word) &&
		$stable(steps_done))
		else $error("result word changed while stalled");

	// one item at a time: the input side closes right after a word is taken
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input accepted while an item is in flight");

	// only a data read returns a word, and a read never reports a stop
	a_read_ok: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (read_word != 16'd0) |-> status == trc_pkg::ST_OK)
		else $error("read word with non-ok status");

endmodule

bind two_register_cpu_core trc_checker u_trc_checker (.*);
`default_nettype wire
